### rtl/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg: quadrature position counter package
// Payload types, the x4 step table and the position range constants.
// ----------------------------------------------------------------------------
package qpc_pkg;

  localparam int POS_W   = 32;
  localparam int LIMIT_W = 32;
  // the limit compares run on full signed values
  localparam int CMP_W   = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_LIMIT  = 2'd0,
    REG_UPPER_LIMIT  = 2'd1,
    REG_LOWER_ENABLE = 2'd2,
    REG_UPPER_ENABLE = 2'd3
  } cfg_reg_t;

  localparam logic        PHASE_A = 1'b0;
  localparam logic        PHASE_B = 1'b1;
  localparam logic        IDLE_LEVEL = 1'b1;

  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_FWD  = 2'sd1;
  localparam logic signed [1:0] STEP_BWD  = -2'sd1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // index is {old a, old b, new a, new b}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    STEP_NONE, STEP_FWD,  STEP_BWD,  STEP_NONE,
    STEP_BWD,  STEP_NONE, STEP_NONE, STEP_FWD,
    STEP_FWD,  STEP_NONE, STEP_NONE, STEP_BWD,
    STEP_NONE, STEP_BWD,  STEP_FWD,  STEP_NONE
  };

  typedef struct packed {
    logic phase_select;
    logic new_level;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0]       step_direction;
    logic signed [POS_W-1:0] position;
    logic                    below_lower;
    logic                    above_upper;
  } out_item_t;

endpackage

### rtl/quadrature_position_counter_unit.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter_unit: x4 quadrature decoder with position count
// Registers: input register, then result register, with the level and position
// update combinational between them; a full, stalled result stage holds the input.
// Throughput: one edge event per cycle while the result side does not stall.
// Reset: levels a and b go to 1, position to 0, limits to the full 32-bit
// range and both alarm enables to 0; both stages come up empty.
// ----------------------------------------------------------------------------
module quadrature_position_counter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  qpc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output qpc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [qpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qpc_pkg::LIMIT_W-1:0]         cfg_wdata
);

  // configuration
  logic signed [qpc_pkg::LIMIT_W-1:0] lower_limit_r;
  logic signed [qpc_pkg::LIMIT_W-1:0] upper_limit_r;
  logic                               lower_en_r;
  logic                               upper_en_r;

  // decoder state
  logic                               level_a_r;
  logic                               level_b_r;
  logic signed [qpc_pkg::POS_W-1:0]   pos_r;

  // input stage and result stage
  logic                               s1_valid_r;
  qpc_pkg::in_item_t                  s1_data_r;
  logic                               out_valid_r;
  qpc_pkg::out_item_t                 out_data_r;

  logic                               out_free;
  logic                               advance;
  logic                               in_accept;
  logic                               level_a_nxt;
  logic                               level_b_nxt;
  logic [3:0]                         step_idx;
  logic signed [1:0]                  step;
  logic signed [qpc_pkg::POS_W-1:0]   pos_nxt;
  logic signed [qpc_pkg::CMP_W-1:0]   pos_ext;
  logic signed [qpc_pkg::CMP_W-1:0]   lower_ext;
  logic signed [qpc_pkg::CMP_W-1:0]   upper_ext;
  qpc_pkg::out_item_t                 out_data_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    level_a_nxt = level_a_r;
    level_b_nxt = level_b_r;
    if (s1_data_r.phase_select == qpc_pkg::PHASE_A) begin
      level_a_nxt = s1_data_r.new_level;
    end else begin
      level_b_nxt = s1_data_r.new_level;
    end
    step_idx = {level_a_r, level_b_r, level_a_nxt, level_b_nxt};
    step     = qpc_pkg::STEP_TABLE[step_idx];

    // saturate at the ends of the position range
    pos_nxt = pos_r;
    if (step == qpc_pkg::STEP_FWD && pos_r != qpc_pkg::POS_MAX) begin
      pos_nxt = pos_r + qpc_pkg::POS_W'(1);
    end else if (step == qpc_pkg::STEP_BWD && pos_r != qpc_pkg::POS_MIN) begin
      pos_nxt = pos_r - qpc_pkg::POS_W'(1);
    end

    pos_ext   = qpc_pkg::CMP_W'(pos_nxt);
    lower_ext = qpc_pkg::CMP_W'(lower_limit_r);
    upper_ext = qpc_pkg::CMP_W'(upper_limit_r);

    out_data_nxt.step_direction = step;
    out_data_nxt.position       = pos_nxt;
    out_data_nxt.below_lower    = lower_en_r && (pos_ext <= lower_ext);
    out_data_nxt.above_upper    = upper_en_r && (pos_ext >= upper_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_limit_r <= {1'b1, {(qpc_pkg::LIMIT_W-1){1'b0}}};
      upper_limit_r <= {1'b0, {(qpc_pkg::LIMIT_W-1){1'b1}}};
      lower_en_r    <= 1'b0;
      upper_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        qpc_pkg::REG_LOWER_LIMIT:  lower_limit_r <= cfg_wdata;
        qpc_pkg::REG_UPPER_LIMIT:  upper_limit_r <= cfg_wdata;
        qpc_pkg::REG_LOWER_ENABLE: lower_en_r    <= cfg_wdata[0];
        qpc_pkg::REG_UPPER_ENABLE: upper_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_a_r   <= qpc_pkg::IDLE_LEVEL;
      level_b_r   <= qpc_pkg::IDLE_LEVEL;
      pos_r       <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        level_a_r   <= level_a_nxt;
        level_b_r   <= level_b_nxt;
        pos_r       <= pos_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // the held request only waits on a full, stalled result stage
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while result stage can move");

  // a request with no step leaves the position alone
  a_no_step_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step == qpc_pkg::STEP_NONE) |=> pos_r == $past(pos_r))
    else $error("position moved without a step");

  // the selected phase takes the requested level
  a_level_taken: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ((($past(s1_data_r.phase_select) == qpc_pkg::PHASE_A) ? level_a_r
                 : level_b_r) == $past(s1_data_r.new_level)))
    else $error("phase level not updated");

  // step code 2 is never produced
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.step_direction != 2'sb10)
    else $error("illegal step code");

  // the result position tracks the counter
  a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_data_r.position == pos_r)
    else $error("result position differs from counter");

endmodule

### bench/quadrature_position_counter_unit_tb.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter_unit_tb: self-checking bench for the x4 decoder
// Sends edge events through the valid/stall request channel, predicts every
// report (step, saturating position, limit flags) with a local decoder model
// and checks reports in order. A short directed table comes first, then runs
// of clean forward and backward rotation mixed with noise, under several
// limit and enable settings, with random idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module quadrature_position_counter_unit_tb;

  localparam int          N_DIRECTED      = 22;
  localparam int          EXTREME_ROW     = 16;
  localparam int          N_PHASES        = 8;
  localparam int          EDGES_PER_PHASE = 235;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  localparam logic signed [qpc_pkg::POS_W-1:0] POS_TOP =
    {1'b0, {(qpc_pkg::POS_W-1){1'b1}}};
  localparam logic signed [qpc_pkg::POS_W-1:0] POS_BOTTOM =
    {1'b1, {(qpc_pkg::POS_W-1){1'b0}}};

  // step for {old a, old b, new a, new b}
  localparam int STEP_OF [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

  typedef struct packed {
    qpc_pkg::in_item_t  ev;
    logic               use_lit;
    qpc_pkg::out_item_t lit;
  } dir_row_t;

  // walk every reachable step index forward and back, then extreme limits
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b1, '{qpc_pkg::STEP_FWD,  1, 1'b0, 1'b0}},
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b1, '{qpc_pkg::STEP_NONE, 1, 1'b0, 1'b0}},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_A, 1'b1}, 1'b0, '0},
    '{'{qpc_pkg::PHASE_B, 1'b1}, 1'b0, '0},
    // lower limit at the top, upper at the bottom: both flags always set
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b1, '{qpc_pkg::STEP_FWD,  -3, 1'b1, 1'b1}},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b1, '{qpc_pkg::STEP_FWD,  -2, 1'b1, 1'b1}},
    '{'{qpc_pkg::PHASE_B, 1'b0}, 1'b1, '{qpc_pkg::STEP_NONE, -2, 1'b1, 1'b1}},
    '{'{qpc_pkg::PHASE_A, 1'b1}, 1'b1, '{qpc_pkg::STEP_BWD,  -3, 1'b1, 1'b1}},
    '{'{qpc_pkg::PHASE_A, 1'b0}, 1'b1, '{qpc_pkg::STEP_FWD,  -2, 1'b1, 1'b1}},
    '{'{qpc_pkg::PHASE_B, 1'b1}, 1'b1, '{qpc_pkg::STEP_FWD,  -1, 1'b1, 1'b1}}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  qpc_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  qpc_pkg::out_item_t            out_data;
  logic                          cfg_we;
  logic [qpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qpc_pkg::LIMIT_W-1:0]   cfg_wdata;

  // decoder model state and its copy of the registers
  logic                               lvl_a;
  logic                               lvl_b;
  logic signed [qpc_pkg::POS_W-1:0]   count_pos;
  logic signed [qpc_pkg::LIMIT_W-1:0] lower_lim;
  logic signed [qpc_pkg::LIMIT_W-1:0] upper_lim;
  logic                               lower_en;
  logic                               upper_en;

  qpc_pkg::out_item_t awaited_reports [$];
  int unsigned        edges_sent;
  int unsigned        reports_checked;
  int unsigned        mismatches;
  int unsigned        settings_used;
  int unsigned        cycle_count;
  int unsigned        steady_left;
  logic               calm;

  quadrature_position_counter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic qpc_pkg::out_item_t decode_edge(qpc_pkg::in_item_t ev);
    logic [3:0]         idx;
    int                 step;
    qpc_pkg::out_item_t rep;
    idx[3] = lvl_a;
    idx[2] = lvl_b;
    if (ev.phase_select == qpc_pkg::PHASE_A) lvl_a = ev.new_level;
    else lvl_b = ev.new_level;
    idx[1] = lvl_a;
    idx[0] = lvl_b;
    step = STEP_OF[idx];
    if (step > 0 && count_pos != POS_TOP) count_pos = count_pos + 1;
    else if (step < 0 && count_pos != POS_BOTTOM) count_pos = count_pos - 1;
    rep.step_direction = step[1:0];
    rep.position       = count_pos;
    // compares run on full signed values
    rep.below_lower    = lower_en && (longint'(count_pos) <= longint'(lower_lim));
    rep.above_upper    = upper_en && (longint'(count_pos) >= longint'(upper_lim));
    return rep;
  endfunction

  task automatic note_mismatch(string what, qpc_pkg::out_item_t want,
                               qpc_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected step %0d pos %0d lo %0b hi %0b, got step %0d pos %0d lo %0b hi %0b",
               what, want.step_direction, want.position, want.below_lower,
               want.above_upper, got.step_direction, got.position, got.below_lower,
               got.above_upper);
  endtask

  always @(posedge clk) begin
    qpc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_checked++;
      if (awaited_reports.size() == 0) begin
        note_mismatch("report with no request pending", '0, out_data);
      end else begin
        want = awaited_reports.pop_front();
        if (want.step_direction !== out_data.step_direction ||
            want.position !== out_data.position ||
            want.below_lower !== out_data.below_lower ||
            want.above_upper !== out_data.above_upper)
          note_mismatch("report mismatch", want, out_data);
      end
    end
  end

  // result side stall bursts, with quiet stretches in between
  initial begin : stall_bursts
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm) begin
        case ($urandom_range(0, 11))
          0, 1: begin
            n = $urandom_range(1, 10);
            out_stall <= 1'b1;
            repeat (n) @(posedge clk);
            out_stall <= 1'b0;
          end
          2: repeat ($urandom_range(30, 100)) @(posedge clk);
          default: ;
        endcase
      end
    end
  end

  task automatic maybe_pause();
    int unsigned n;
    if (calm) return;
    if (steady_left != 0) begin
      steady_left--;
      return;
    end
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        n = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      3: steady_left = $urandom_range(20, 60);
      default: ;
    endcase
  endtask

  // one request per edge event; prediction is made in issue order
  task automatic send_edge(qpc_pkg::in_item_t ev, logic use_lit,
                           qpc_pkg::out_item_t lit);
    qpc_pkg::out_item_t pred;
    pred = decode_edge(ev);
    awaited_reports.push_back(use_lit ? lit : pred);
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    edges_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [qpc_pkg::LIMIT_W-1:0] lo,
                              logic [qpc_pkg::LIMIT_W-1:0] hi,
                              logic lo_on, logic hi_on);
    qpc_pkg::cfg_reg_t           regs [4];
    logic [qpc_pkg::LIMIT_W-1:0] vals [4];
    regs = '{qpc_pkg::REG_LOWER_LIMIT, qpc_pkg::REG_UPPER_LIMIT,
             qpc_pkg::REG_LOWER_ENABLE, qpc_pkg::REG_UPPER_ENABLE};
    vals[0] = lo;
    vals[1] = hi;
    // junk above bit 0 of the enables must be dropped
    vals[2] = $urandom();
    vals[2][0] = lo_on;
    vals[3] = $urandom();
    vals[3][0] = hi_on;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    lower_lim = lo;
    upper_lim = hi;
    lower_en  = lo_on;
    upper_en  = hi_on;
    settings_used++;
  endtask

  task automatic run_rotation(int unsigned n_edges);
    int unsigned       left;
    int unsigned       run;
    logic              fwd;
    qpc_pkg::in_item_t ev;
    left = n_edges;
    while (left != 0) begin
      run = $urandom_range(1, 40);
      fwd = 1'($urandom_range(0, 1));
      while (run != 0 && left != 0) begin
        if ($urandom_range(0, 99) < 85) begin
          // forward toggles b when the levels match, backward toggles a
          ev.phase_select = ((lvl_a == lvl_b) == fwd) ? qpc_pkg::PHASE_B
                                                      : qpc_pkg::PHASE_A;
          ev.new_level    = (ev.phase_select == qpc_pkg::PHASE_A) ? ~lvl_a : ~lvl_b;
        end else begin
          ev.phase_select = 1'($urandom_range(0, 1));
          ev.new_level    = 1'($urandom_range(0, 1));
        end
        maybe_pause();
        send_edge(ev, 1'b0, '0);
        run--;
        left--;
      end
    end
  endtask

  initial begin : stimulus
    longint                      base;
    logic [qpc_pkg::LIMIT_W-1:0] lo;
    logic [qpc_pkg::LIMIT_W-1:0] hi;
    logic                        lo_on;
    logic                        hi_on;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_index       = qpc_pkg::REG_LOWER_LIMIT;
    cfg_wdata       = '0;
    lvl_a           = qpc_pkg::IDLE_LEVEL;
    lvl_b           = qpc_pkg::IDLE_LEVEL;
    count_pos       = '0;
    lower_lim       = 32'h8000_0000;
    upper_lim       = 32'h7FFF_FFFF;
    lower_en        = 1'b0;
    upper_en        = 1'b0;
    edges_sent      = 0;
    settings_used   = 0;
    steady_left     = 0;
    calm            = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == EXTREME_ROW) begin
        drain();
        program_regs(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
      end
      maybe_pause();
      send_edge(DIRECTED[i].ev, DIRECTED[i].use_lit, DIRECTED[i].lit);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm  = (ph == N_PHASES - 1);
      base  = longint'(count_pos);
      lo    = qpc_pkg::LIMIT_W'(base - longint'($urandom_range(0, 40)));
      hi    = qpc_pkg::LIMIT_W'(base + longint'($urandom_range(0, 40)));
      lo_on = 1'($urandom_range(0, 1));
      hi_on = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; lo_on = 1'b1; hi_on = 1'b1;
        end
        1: begin
          lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; lo_on = 1'b1; hi_on = 1'b1;
        end
        2: begin
          lo = $urandom(); hi = $urandom();
        end
        N_PHASES - 1: begin
          lo_on = 1'b1; hi_on = 1'b1;
        end
        default: ;
      endcase
      program_regs(lo, hi, lo_on, hi_on);
      run_rotation(EDGES_PER_PHASE);
      drain();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("%0d edge events sent, %0d reports checked, %0d limit settings",
             edges_sent, reports_checked, settings_used);
    $display("covered both rotation directions, repeated levels, noise and limit flags");
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
